### rtl/aesctr_pkg.sv
// aesctr_pkg: shared types, constants and round functions for the aes-128 ctr core
// no dependencies
package aesctr_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int BYTE_LIMIT     = 1024;
	localparam int QDEPTH         = 2;

	localparam logic [1:0] REG_KEY_LOW     = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH    = 2'd1;
	localparam logic [1:0] REG_NONCE_WORD  = 2'd2;
	localparam logic [1:0] REG_START_COUNT = 2'd3;

	// classified command passed from front to back
	typedef struct packed {
		logic        rekey;
		logic [10:0] nbytes;
	} cmd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// byte i of a state sits at bits [8i+7:8i] (little-endian)
	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[8*(4*c+i) +: 8] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] t);
		logic [127:0] s;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = t[8*(4*c) +: 8];
			a1 = t[8*(4*c+1) +: 8];
			a2 = t[8*(4*c+2) +: 8];
			a3 = t[8*(4*c+3) +: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			s[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
			s[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			s[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			s[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		mix_cols = s;
	endfunction

	// next round key from the previous one
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t;
		logic [127:0] n;
		t[7:0]   = SBOX[k[111:104]] ^ rc;
		t[15:8]  = SBOX[k[119:112]];
		t[23:16] = SBOX[k[127:120]];
		t[31:24] = SBOX[k[103:96]];
		n[31:0]   = k[31:0] ^ t;
		n[63:32]  = k[63:32] ^ n[31:0];
		n[95:64]  = k[95:64] ^ n[63:32];
		n[127:96] = k[127:96] ^ n[95:64];
		next_key = n;
	endfunction

	function automatic logic [7:0] rcon_next(input logic [7:0] rc);
		rcon_next = xtime(rc);
	endfunction

endpackage

### rtl/aes128_counter_keystream_core.sv
// aes128_counter_keystream_core: top level of the aes-128 ctr keystream block
// depends on aesctr_pkg, aesctr_front, aesctr_back
//
// input channel: push/full with mode and byte_count. mode 1 re-expands the key
// from key_low/key_high and reloads the counter from start_count (the command
// is taken while idle, then the key schedule is expanded).
// mode 0 requests byte_count bytes, capped to min(1024, MAX_BLOCKS*16);
// a request of zero bytes makes no result.
// result channel: empty/pop with data_low, data_high, valid_bytes, last_block.
// each block passes through the single round unit one round at a time, after
// a setup step per request that loads the first counter block.
// a two-entry command queue sits between the front and the round unit, so
// requests keep being taken while a block is being computed.
// the round unit stalls holding its last round while the result register
// is still occupied and pop is low.
// after reset the block expands the all-zero key;
// commands are queued meanwhile. config writes go straight to registers.
module aes128_counter_keystream_core import aesctr_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [10:0] byte_count,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] data_low,
	output logic [63:0] data_high,
	output logic [4:0]  valid_bytes,
	output logic        last_block,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0] key_low_q, key_high_q, nonce_q, start_q;
	logic        cmd_valid, cmd_take;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			nonce_q <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:     key_low_q <= cfg_data;
				REG_KEY_HIGH:    key_high_q <= cfg_data;
				REG_NONCE_WORD:  nonce_q <= cfg_data;
				REG_START_COUNT: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	aesctr_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
		.clk, .arst_n, .push, .full, .mode, .byte_count,
		.cmd_valid, .cmd_take, .cmd
	);

	aesctr_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.key({key_high_q, key_low_q}), .nonce(nonce_q), .start_cnt(start_q),
		.empty, .pop, .data_low, .data_high, .valid_bytes, .last_block
	);
endmodule

### rtl/aesctr_front.sv
// aesctr_front: accepts requests, saturates length, queues commands
// depends on aesctr_pkg
module aesctr_front import aesctr_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [10:0] byte_count,
	output logic        cmd_valid,
	input  logic        cmd_take,
	output cmd_t        cmd
);
	localparam int CAP_I = (MAX_BLOCKS * 16 < BYTE_LIMIT) ? MAX_BLOCKS * 16 : BYTE_LIMIT;
	localparam logic [10:0] CAP = 11'(CAP_I);

	cmd_t        q_q [QDEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	cmd_t        in_cmd;
	logic        wr;

	always_comb begin
		in_cmd.rekey  = mode;
		in_cmd.nbytes = (byte_count > CAP) ? CAP : byte_count;
	end

	assign full = (cnt_q == 2'(QDEPTH));
	// zero-length generate produces nothing, so drop it here
	assign wr = push && !full && (mode || in_cmd.nbytes != 11'd0);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(cmd_take);
		end
	end
endmodule

### rtl/aesctr_back.sv
// aesctr_back: key expansion, one-round-per-cycle cipher, counter, result register
// depends on aesctr_pkg. the cipher stalls its last round while a result waits
module aesctr_back import aesctr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_take,
	input  cmd_t         cmd,
	input  logic [127:0] key,
	input  logic [63:0]  nonce,
	input  logic [63:0]  start_cnt,
	output logic         empty,
	input  logic         pop,
	output logic [63:0]  data_low,
	output logic [63:0]  data_high,
	output logic [4:0]   valid_bytes,
	output logic         last_block
);
	typedef enum logic [1:0] {IDLE, EXPAND, RUN} state_t;

	state_t        state_q;
	logic [127:0]  rk_q [11];
	logic [127:0]  st_q, kx_q;
	logic [7:0]    rc_q;
	logic [3:0]    rnd_q;
	logic [10:0]   left_q;
	logic [63:0]   ctr_q;
	logic          ov_q;
	logic [127:0]  od_q;
	logic [4:0]    ovb_q;
	logic          olast_q;
	logic [127:0]  ss, nxt;

	assign empty = !ov_q;
	assign data_low = od_q[63:0];
	assign data_high = od_q[127:64];
	assign valid_bytes = ovb_q;
	assign last_block = olast_q;
	assign cmd_take = (state_q == IDLE) && cmd_valid;

	always_comb begin
		ss = sub_shift(st_q);
		nxt = ((rnd_q == 4'd10) ? ss : mix_cols(ss)) ^ rk_q[rnd_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == EXPAND) rk_q[rnd_q] <= kx_q;
		if (cmd_take && !cmd.rekey) st_q <= {nonce, ctr_q} ^ rk_q[0];
		else if (state_q == RUN && rnd_q != 4'd0) begin
			if (rnd_q != 4'd10) st_q <= nxt;
			else if (!ov_q || pop) st_q <= {nonce, ctr_q + 64'd1} ^ rk_q[0];
		end
		if (state_q == RUN && rnd_q == 4'd10 && (!ov_q || pop)) begin
			od_q <= nxt;
			ovb_q <= (left_q <= 11'd16) ? left_q[4:0] : 5'd16;
			olast_q <= (left_q <= 11'd16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// reset schedule is the expansion of the zero key
			state_q <= EXPAND;
			rnd_q <= 4'd0;
			rc_q <= 8'h01;
			kx_q <= '0;
			ctr_q <= 64'd0;
			left_q <= 11'd0;
			ov_q <= 1'b0;
		end else begin
			if (pop && ov_q) ov_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (cmd_take) begin
						if (cmd.rekey) begin
							state_q <= EXPAND;
							rnd_q <= 4'd0;
							rc_q <= 8'h01;
							kx_q <= key;
							ctr_q <= start_cnt;
						end else begin
							state_q <= RUN;
							rnd_q <= 4'd1;
							left_q <= cmd.nbytes;
						end
					end
				end
				EXPAND: begin
					kx_q <= next_key(kx_q, rc_q);
					rc_q <= rcon_next(rc_q);
					if (rnd_q == 4'd10) state_q <= IDLE;
					else rnd_q <= rnd_q + 4'd1;
				end
				RUN: begin
					if (rnd_q != 4'd10) rnd_q <= rnd_q + 4'd1;
					else if (!ov_q || pop) begin
						// final round lands in the result register
						ov_q <= 1'b1;
						ctr_q <= ctr_q + 64'd1;
						if (left_q <= 11'd16) state_q <= IDLE;
						else begin
							left_q <= left_q - 11'd16;
							rnd_q <= 4'd1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### rtl/aesctr_checker.sv
// aesctr_checker: port-level assertions for the keystream core
// depends on aes128_counter_keystream_core (bound to it)
module aesctr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [4:0] valid_bytes,
	input logic       last_block
);
	a_vb_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (valid_bytes != 5'd0 && valid_bytes <= 5'd16))
		else $error("valid_bytes out of range");
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && valid_bytes != 5'd16) |-> last_block)
		else $error("partial block not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(valid_bytes) && $stable(last_block)))
		else $error("result changed while stalled");
endmodule

bind aes128_counter_keystream_core aesctr_checker u_chk (
	.clk, .arst_n, .empty, .pop, .valid_bytes, .last_block
);

### tb/aes128_counter_keystream_core_test.sv
// aes128_counter_keystream_core_test: self-checking bench for the aes-128 ctr keystream core
// depends on aesctr_pkg and aes128_counter_keystream_core
// own aes-128 ctr predictor, queue-fed driver, popping monitor, several key/nonce settings
module aes128_counter_keystream_core_test;
	import aesctr_pkg::*;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  nvalid;
		logic        last;
	} ks_block_t;

	typedef struct {
		logic        rekey;
		logic [10:0] nbytes;
	} request_t;

	localparam logic [7:0] ROUND_CONST [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
	localparam int GEN_CAP = 1024;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        mode;
	logic [10:0] byte_count;
	logic        empty;
	logic        pop;
	logic [63:0] data_low;
	logic [63:0] data_high;
	logic [4:0]  valid_bytes;
	logic        last_block;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	aes128_counter_keystream_core u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.byte_count(byte_count), .empty(empty), .pop(pop), .data_low(data_low),
		.data_high(data_high), .valid_bytes(valid_bytes), .last_block(last_block),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [63:0]  key_lo_reg, key_hi_reg, nonce_reg, start_reg;
	logic [127:0] sched [11];
	logic [63:0]  ctr;

	request_t  pending_q [$];
	ks_block_t keystream_q [$];
	int        send_idle_pct;
	int        recv_stall_pct;
	int        errors;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic expand_schedule(input logic [63:0] lo, input logic [63:0] hi);
		logic [127:0] p;
		logic [31:0]  t;
		logic [31:0]  w0, w1, w2, w3;
		sched[0] = {hi, lo};
		for (int r = 1; r <= 10; r++) begin
			p = sched[r-1];
			t = {SBOX[p[103:96]], SBOX[p[127:120]], SBOX[p[119:112]],
				SBOX[p[111:104]] ^ ROUND_CONST[r-1]};
			w0 = p[31:0] ^ t;
			w1 = p[63:32] ^ w0;
			w2 = p[95:64] ^ w1;
			w3 = p[127:96] ^ w2;
			sched[r] = {w3, w2, w1, w0};
		end
	endtask

	function automatic logic [127:0] cipher(input logic [127:0] pt);
		logic [127:0] s, t;
		logic [7:0]   a0, a1, a2, a3, al;
		s = pt ^ sched[0];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[8*(4*c+i) +: 8] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[8*(4*c) +: 8];
					a1 = t[8*(4*c+1) +: 8];
					a2 = t[8*(4*c+2) +: 8];
					a3 = t[8*(4*c+3) +: 8];
					al = a0 ^ a1 ^ a2 ^ a3;
					s[8*(4*c) +: 8]   = a0 ^ al ^ xt(a0 ^ a1);
					s[8*(4*c+1) +: 8] = a1 ^ al ^ xt(a1 ^ a2);
					s[8*(4*c+2) +: 8] = a2 ^ al ^ xt(a2 ^ a3);
					s[8*(4*c+3) +: 8] = a3 ^ al ^ xt(a3 ^ a0);
				end
			end else begin
				s = t;
			end
			s = s ^ sched[r];
		end
		return s;
	endfunction

	task automatic predict_keystream(input logic rekey, input logic [10:0] nbytes);
		int n, nblk;
		logic [127:0] ct;
		ks_block_t e;
		if (rekey) begin
			expand_schedule(key_lo_reg, key_hi_reg);
			ctr = start_reg;
		end else begin
			n = (nbytes > GEN_CAP) ? GEN_CAP : nbytes;
			nblk = (n + 15) / 16;
			for (int b = 0; b < nblk; b++) begin
				ct = cipher({nonce_reg, ctr});
				ctr = ctr + 64'd1;
				e.lo = ct[63:0];
				e.hi = ct[127:64];
				e.last = (b == nblk - 1);
				e.nvalid = (e.last && (n % 16 != 0)) ? 5'(n % 16) : 5'd16;
				keystream_q.push_back(e);
			end
		end
	endtask

	// driver: one request per transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			mode <= 1'b0;
			byte_count <= '0;
		end else begin
			if (push && !full)
				predict_keystream(mode, byte_count);
			if (!push || !full) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					mode <= pending_q[0].rekey;
					byte_count <= pending_q[0].nbytes;
					push <= 1'b1;
					void'(pending_q.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: compare every result transfer with the oldest expected block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (keystream_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected block %h_%h vb=%0d last=%0b",
							data_high, data_low, valid_bytes, last_block);
				end else begin
					if (data_low !== keystream_q[0].lo || data_high !== keystream_q[0].hi ||
						valid_bytes !== keystream_q[0].nvalid ||
						last_block !== keystream_q[0].last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h_%h vb=%0d last=%0b got %h_%h vb=%0d last=%0b",
								keystream_q[0].hi, keystream_q[0].lo, keystream_q[0].nvalid,
								keystream_q[0].last, data_high, data_low, valid_bytes,
								last_block);
					end
					void'(keystream_q.pop_front());
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_req(input logic rekey, input logic [10:0] nbytes);
		request_t q;
		q.rekey = rekey;
		q.nbytes = nbytes;
		pending_q.push_back(q);
	endtask

	// wait for every request taken and every block delivered, then let rekeys drain
	task automatic wait_quiet();
		while (pending_q.size() > 0 || push || keystream_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_KEY_LOW:     key_lo_reg = val;
			REG_KEY_HIGH:    key_hi_reg = val;
			REG_NONCE_WORD:  nonce_reg = val;
			REG_START_COUNT: start_reg = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setting(input logic [63:0] klo, input logic [63:0] khi,
		input logic [63:0] nw, input logic [63:0] sc);
		wait_quiet();
		write_reg(REG_KEY_LOW, klo);
		write_reg(REG_KEY_HIGH, khi);
		write_reg(REG_NONCE_WORD, nw);
		write_reg(REG_START_COUNT, sc);
		queue_req(1'b1, 11'($urandom_range(2047)));
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_requests(input int cnt);
		int sel;
		for (int k = 0; k < cnt; k++) begin
			sel = $urandom_range(99);
			if (sel < 8)
				queue_req(1'b1, 11'($urandom_range(2047)));
			else if (sel < 12)
				queue_req(1'b0, 11'd0);
			else if (sel < 16)
				queue_req(1'b0, 11'($urandom_range(2047, 65)));
			else
				queue_req(1'b0, 11'($urandom_range(64, 1)));
		end
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 6;
		recv_stall_pct = 86;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key_lo_reg = '0;
		key_hi_reg = '0;
		nonce_reg = '0;
		start_reg = '0;
		ctr = '0;
		expand_schedule('0, '0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset key, length edges, oversized and ignored lengths
		queue_req(1'b0, 11'd1);
		queue_req(1'b0, 11'd0);
		queue_req(1'b0, 11'd15);
		queue_req(1'b0, 11'd16);
		queue_req(1'b0, 11'd17);
		queue_req(1'b0, 11'd31);
		queue_req(1'b0, 11'd32);
		queue_req(1'b0, 11'd1024);
		queue_req(1'b0, 11'd1025);
		queue_req(1'b0, 11'd2047);
		queue_req(1'b1, 11'd2047);
		queue_req(1'b0, 11'd5);
		// counter wrap with all-ones key and nonce
		load_setting('1, '1, '1, 64'hffff_ffff_ffff_fffe);
		queue_req(1'b0, 11'd48);
		queue_req(1'b1, 11'd0);
		queue_req(1'b0, 11'd40);
		load_setting('0, '0, '0, '0);
		queue_req(1'b0, 11'd16);

		load_setting(rnd64(), rnd64(), rnd64(), rnd64());
		random_requests(45);
		load_setting(rnd64(), rnd64(), rnd64(), '1);
		random_requests(45);

		wait_quiet();
		send_idle_pct = 86;
		recv_stall_pct = 6;
		load_setting(rnd64(), rnd64(), rnd64(), rnd64());
		random_requests(45);
		load_setting(rnd64(), '0, '1, rnd64());
		random_requests(45);

		wait_quiet();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_setting(rnd64(), rnd64(), rnd64(), rnd64());
		random_requests(45);

		wait_quiet();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#24000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### aes128_counter_keystream_core.f
rtl/aesctr_pkg.sv
rtl/aesctr_front.sv
rtl/aesctr_back.sv
rtl/aes128_counter_keystream_core.sv
rtl/aesctr_checker.sv
tb/aes128_counter_keystream_core_test.sv
